// ----- rtl/programmable_interrupt_controller_unit_assert.svh -----
// Assertion macros for the programmable interrupt controller.
// Included by the top level; needs no package and no other file.
`ifndef PROGRAMMABLE_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH
`define PROGRAMMABLE_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define PICU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PICU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pic_pkg.sv -----
// Shared types, command codes and constants for the interrupt controller.
// No dependencies; used by pic_step and the top level.
`default_nettype none

package pic_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_LEVEL = 2'd3
  } cmd_t;

  // Initialization sequence steps.
  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_ICW2 = 3'd2;
  localparam logic [2:0] STEP_ICW3 = 3'd3;
  localparam logic [2:0] STEP_ICW4 = 3'd4;
  localparam logic [2:0] STEP_DONE = 3'd5;

  // OCW2 action codes, data bits 7..5.
  localparam logic [2:0] OCW2_NONSPECIFIC_EOI = 3'd1;
  localparam logic [2:0] OCW2_SPECIFIC_EOI    = 3'd3;

  localparam logic [7:0] MASK_RESET  = 8'hFF;
  localparam logic [7:0] VECTOR_MASK = 8'hF8;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic [7:0] request_bits;
    logic [7:0] service_bits;
    logic [7:0] mask_bits;
    logic       read_service;
    logic [2:0] init_step;
    logic [7:0] init_word_one;
    logic [7:0] vector_offset;
  } pic_state_t;

  typedef struct packed {
    logic       level;
    logic [2:0] irq_line;
    logic [7:0] data;
    logic       port;
    cmd_t       command;
  } pic_cmd_t;

  // Field order matches the output tdata layout, lowest bits last.
  typedef struct packed {
    logic [7:0] vector_base;
    logic       int_pending;
    logic [2:0] ack_irq;
    logic       ack_valid;
    logic [7:0] read_data;
  } pic_result_t;

  function automatic logic [7:0] line_bit(input logic [2:0] n);
    line_bit = 8'd1 << n;
  endfunction

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [2:0] lowest_set(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    lowest_set = idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pic_step.sv -----
// Next-state and result decode for one controller command.
// Purely combinational; depends on pic_pkg.
`default_nettype none

module pic_step (
  input  pic_pkg::pic_state_t  cur,
  input  pic_pkg::pic_cmd_t    cmd,
  output pic_pkg::pic_state_t  nxt,
  output pic_pkg::pic_result_t res
);

  logic [7:0] ready;
  logic [2:0] grant;

  assign ready = cur.request_bits & ~cur.mask_bits;
  assign grant = pic_pkg::lowest_set(ready);

  always_comb begin
    nxt = cur;
    res = '0;
    case (cmd.command)
      pic_pkg::CMD_READ: begin
        if (cmd.port) begin
          res.read_data = cur.mask_bits;
        end else begin
          res.read_data = cur.read_service ? cur.service_bits : cur.request_bits;
        end
      end
      pic_pkg::CMD_WRITE: begin
        if (!cmd.port) begin
          if (cmd.data[4]) begin
            // ICW1 restarts initialization.
            nxt.mask_bits     = '0;
            nxt.init_word_one = cmd.data;
            nxt.init_step     = pic_pkg::STEP_ICW2;
            nxt.read_service  = 1'b0;
          end else if (!cmd.data[3]) begin
            case (cmd.data[7:5])
              pic_pkg::OCW2_SPECIFIC_EOI: begin
                nxt.request_bits = cur.request_bits & ~pic_pkg::line_bit(cmd.data[2:0]);
                nxt.service_bits = cur.service_bits & ~pic_pkg::line_bit(cmd.data[2:0]);
              end
              pic_pkg::OCW2_NONSPECIFIC_EOI: begin
                nxt.request_bits = cur.request_bits & ~cur.service_bits;
                nxt.service_bits = '0;
              end
              default: begin
              end
            endcase
          end else if (cmd.data[1]) begin
            nxt.read_service = cmd.data[0];
          end
        end else begin
          case (cur.init_step)
            pic_pkg::STEP_ICW2: begin
              nxt.vector_offset = cmd.data & pic_pkg::VECTOR_MASK;
              nxt.init_step = cur.init_word_one[1] ? pic_pkg::STEP_ICW4 : pic_pkg::STEP_ICW3;
            end
            pic_pkg::STEP_ICW3: begin
              nxt.init_step = cur.init_word_one[0] ? pic_pkg::STEP_ICW4 : pic_pkg::STEP_DONE;
            end
            pic_pkg::STEP_ICW4: begin
              nxt.init_step = pic_pkg::STEP_DONE;
            end
            pic_pkg::STEP_DONE: begin
              nxt.mask_bits = cmd.data;
            end
            default: begin
            end
          endcase
        end
      end
      pic_pkg::CMD_ACK: begin
        if (|ready) begin
          nxt.request_bits = cur.request_bits & ~pic_pkg::line_bit(grant);
          nxt.service_bits = cur.service_bits | pic_pkg::line_bit(grant);
          res.ack_valid    = 1'b1;
          res.ack_irq      = grant;
        end
      end
      pic_pkg::CMD_LEVEL: begin
        if (cmd.level) begin
          nxt.request_bits = cur.request_bits | pic_pkg::line_bit(cmd.irq_line);
        end else begin
          nxt.request_bits = cur.request_bits & ~pic_pkg::line_bit(cmd.irq_line);
        end
      end
      default: begin
      end
    endcase
    res.int_pending = |(nxt.request_bits & ~nxt.mask_bits);
    res.vector_base = nxt.vector_offset;
  end

endmodule

`default_nettype wire

// ----- rtl/programmable_interrupt_controller_unit.sv -----
// Eight-line programmable interrupt controller, top level.
// Depends on pic_pkg, pic_step and programmable_interrupt_controller_unit_assert.svh.
//
// Usage: every transaction on the slave stream carries one command in tuser
// (a port read, a port write, an interrupt acknowledge or a new line level)
// with its operands in tdata. Each accepted command produces exactly one
// transaction on the master stream with the read byte, the acknowledge
// grant, the pending-interrupt flag and the current vector base.
// The result of a command accepted at one clock edge is registered and
// presented on the master side right after that edge. Throughput is one
// command per cycle while the receiver takes results, set by the single
// output register; the request, in-service and mask registers are updated
// at the same edge as the accept, so the next command already sees them.
// When the receiver stalls, the pending result waits in the output register
// and a new command is still taken in the cycle the result leaves. While the
// output register is full and not being drained, s_axis_tready is low.
// Reset clears all request and in-service bits, masks every line, returns
// the initialization sequence to its start and empties the output register.
`default_nettype none

module programmable_interrupt_controller_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, low bit up: data[7:0], irq_line[10:8], level[11], zero fill[15:12]
  input  wire logic [pic_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser, low bit up: command[1:0], port[2]
  input  wire logic [pic_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata, low bit up: read_data[7:0], ack_valid[8], ack_irq[11:9],
  // int_pending[12], vector_base[20:13], zero fill[23:21]
  output logic [pic_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  `include "programmable_interrupt_controller_unit_assert.svh"

  pic_pkg::pic_state_t  state;
  pic_pkg::pic_state_t  state_next;
  pic_pkg::pic_cmd_t    cmd;
  pic_pkg::pic_result_t step_res;
  pic_pkg::pic_result_t out_res;
  logic                 in_fire;

  // Output register empties this cycle or is already empty.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cmd.command  = pic_pkg::cmd_t'(s_axis_tuser[1:0]);
  assign cmd.port     = s_axis_tuser[2];
  assign cmd.data     = s_axis_tdata[7:0];
  assign cmd.irq_line = s_axis_tdata[10:8];
  assign cmd.level    = s_axis_tdata[11];

  pic_step u_step (
    .cur (state),
    .cmd (cmd),
    .nxt (state_next),
    .res (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.request_bits  <= '0;
      state.service_bits  <= '0;
      state.mask_bits     <= pic_pkg::MASK_RESET;
      state.read_service  <= 1'b0;
      state.init_step     <= pic_pkg::STEP_IDLE;
      state.init_word_one <= '0;
      state.vector_offset <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result payload needs no reset; it is only read while valid.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {(pic_pkg::OUT_DATA_W - $bits(pic_pkg::pic_result_t))'(0), out_res};

  // Reset always leaves the output register empty.
  `PICU_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // A granted line is in service and no longer requested after the accept.
  `PICU_ASSERT(a_grant_moves, clk, rst, (in_fire && step_res.ack_valid) |=> (state.service_bits[$past(step_res.ack_irq)] && !state.request_bits[$past(step_res.ack_irq)]), "granted line not moved to service")

  // The reported pending flag matches the updated request and mask registers.
  `PICU_ASSERT(a_pending_match, clk, rst, in_fire |=> (out_res.int_pending == (|(state.request_bits & ~state.mask_bits))), "pending flag mismatch")

  // The vector base is always aligned to eight vectors.
  `PICU_ASSERT(a_vector_aligned, clk, rst, m_axis_tvalid |-> (out_res.vector_base[2:0] == 3'd0), "vector base misaligned")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the eight-line interrupt controller top level.
// Needs pic_pkg and programmable_interrupt_controller_unit; checks every response
// against a cycle-free shadow of the request, in-service and mask registers.
`default_nettype none

module tb_top;

  // Port select values, address bit zero.
  localparam logic PORT_CTRL = 1'b0;
  localparam logic PORT_MASK = 1'b1;

  // Longest run of cycles with no transaction on either side before the run is abandoned.
  // With either side idling at up to 63 percent, a run of this length does not happen by chance.
  localparam int WATCHDOG_LIMIT = 2000;

  // The block answers from its output register after the accept, so a short tail is enough.
  localparam int DRAIN_TAIL = 8;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  wire                            s_axis_tready;
  logic [pic_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [pic_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  wire                            m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  wire  [pic_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  programmable_interrupt_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the controller registers, updated once per accepted command.
  logic [7:0] shadow_irr;
  logic [7:0] shadow_isr;
  logic [7:0] shadow_imr;
  logic       shadow_read_isr;
  logic [2:0] shadow_step;
  logic [7:0] shadow_icw1;
  logic [7:0] shadow_vector;

  // Responses still owed by the block, oldest first.
  pic_pkg::pic_result_t pending_responses[$];

  // Flow-control knobs, in percent, changed between phases.
  int send_gap_pct = 0;
  int stall_pct    = 0;

  int errors       = 0;
  int cmds_sent    = 0;
  int grants_seen  = 0;
  int eois_seen    = 0;
  int reinits_seen = 0;

  // Computes the response to one command and advances the shadow registers.
  function automatic pic_pkg::pic_result_t predict_pic_response(
      pic_pkg::cmd_t cmd, logic port, logic [7:0] data, logic [2:0] line, logic lvl);
    pic_pkg::pic_result_t rsp;
    logic [7:0]  ready;
    logic [7:0]  sel;
    logic        found;
    rsp   = '0;
    found = 1'b0;
    case (cmd)
      pic_pkg::CMD_READ: begin
        if (port == PORT_MASK) begin
          rsp.read_data = shadow_imr;
        end else begin
          rsp.read_data = shadow_read_isr ? shadow_isr : shadow_irr;
        end
      end
      pic_pkg::CMD_WRITE: begin
        if (port == PORT_CTRL) begin
          if (data[4]) begin
            // ICW1 restarts initialization and unmasks every line.
            shadow_imr      = 8'h00;
            shadow_icw1     = data;
            shadow_step     = pic_pkg::STEP_ICW2;
            shadow_read_isr = 1'b0;
            reinits_seen++;
          end else if (!data[3]) begin
            // OCW2: only the two EOI kinds have an effect.
            if (data[7:5] == pic_pkg::OCW2_SPECIFIC_EOI) begin
              sel        = 8'd1 << data[2:0];
              shadow_irr = shadow_irr & ~sel;
              shadow_isr = shadow_isr & ~sel;
              eois_seen++;
            end else if (data[7:5] == pic_pkg::OCW2_NONSPECIFIC_EOI) begin
              shadow_irr = shadow_irr & ~shadow_isr;
              shadow_isr = 8'h00;
              eois_seen++;
            end
          end else if (data[1]) begin
            // OCW3 with the read-register command bit set.
            shadow_read_isr = data[0];
          end
        end else begin
          case (shadow_step)
            pic_pkg::STEP_ICW2: begin
              shadow_vector = data & pic_pkg::VECTOR_MASK;
              shadow_step   = shadow_icw1[1] ? pic_pkg::STEP_ICW4 : pic_pkg::STEP_ICW3;
            end
            pic_pkg::STEP_ICW3: begin
              shadow_step = shadow_icw1[0] ? pic_pkg::STEP_ICW4 : pic_pkg::STEP_DONE;
            end
            pic_pkg::STEP_ICW4: shadow_step = pic_pkg::STEP_DONE;
            pic_pkg::STEP_DONE: shadow_imr = data;
            default: ;
          endcase
        end
      end
      pic_pkg::CMD_ACK: begin
        ready = shadow_irr & ~shadow_imr;
        for (int i = 0; i < 8; i++) begin
          if (!found && ready[i]) begin
            found         = 1'b1;
            shadow_irr[i] = 1'b0;
            shadow_isr[i] = 1'b1;
            rsp.ack_valid = 1'b1;
            rsp.ack_irq   = 3'(i);
          end
        end
        if (found) begin
          grants_seen++;
        end
      end
      default: begin
        shadow_irr[line] = lvl;
      end
    endcase
    rsp.int_pending = |(shadow_irr & ~shadow_imr);
    rsp.vector_base = shadow_vector;
    return rsp;
  endfunction

  // Sends one command and waits for its accept. Every call starts right after a rising
  // edge; valid is left high so back-to-back commands go out without dropping valid.
  task automatic send_cmd(pic_pkg::cmd_t cmd, logic port, logic [7:0] data,
                          logic [2:0] line, logic lvl);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, lvl, line, data};
    s_axis_tuser  <= {port, cmd};
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    pending_responses.push_back(predict_pic_response(cmd, port, data, line, lvl));
    cmds_sent++;
  endtask

  task automatic pic_read(logic port);
    send_cmd(pic_pkg::CMD_READ, port, 8'($urandom), 3'($urandom), 1'($urandom));
  endtask

  task automatic pic_write(logic port, logic [7:0] data);
    send_cmd(pic_pkg::CMD_WRITE, port, data, 3'($urandom), 1'($urandom));
  endtask

  task automatic pic_ack();
    send_cmd(pic_pkg::CMD_ACK, 1'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
  endtask

  task automatic pic_level(logic [2:0] line, logic lvl);
    send_cmd(pic_pkg::CMD_LEVEL, 1'($urandom), 8'($urandom), line, lvl);
  endtask

  // Holds the sender off until every outstanding response has come back.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Power-on state: all lines masked, port 1 writes ignored before ICW1.
  task automatic test_power_on();
    pic_read(PORT_CTRL);
    pic_read(PORT_MASK);
    pic_level(3'd7, 1'b1);
    pic_ack();
    pic_write(PORT_MASK, 8'h00);
    pic_read(PORT_MASK);
  endtask

  // ICW1 with bit 1 set skips ICW3; a maximal ICW2 shows the low vector bits dropped.
  task automatic test_init_short();
    pic_write(PORT_CTRL, 8'h13);
    pic_write(PORT_MASK, 8'hFF);
    pic_write(PORT_MASK, 8'hAA);
  endtask

  // Grant priority, in-service readback and both EOI kinds.
  task automatic test_ack_and_eoi();
    pic_level(3'd0, 1'b1);
    pic_ack();
    pic_write(PORT_CTRL, 8'h0B);
    pic_read(PORT_CTRL);
    pic_write(PORT_CTRL, 8'h20);
    pic_ack();
    pic_write(PORT_CTRL, 8'h67);
  endtask

  // Masked acknowledge, an OCW2 kind with no effect, OCW3 without its read bit, and
  // the long initialization path through ICW3.
  task automatic test_ocw_and_mask();
    pic_write(PORT_CTRL, 8'h0A);
    pic_write(PORT_MASK, 8'h7F);
    pic_level(3'd0, 1'b1);
    pic_ack();
    pic_write(PORT_CTRL, 8'h40);
    pic_write(PORT_CTRL, 8'h08);
    pic_read(PORT_MASK);
    pic_write(PORT_CTRL, 8'h10);
    pic_write(PORT_MASK, 8'h00);
    pic_write(PORT_MASK, 8'h00);
    pic_level(3'd0, 1'b0);
  endtask

  // Mostly legal traffic on an initialized controller, with full re-init sequences and
  // a share of unconstrained commands as noise.
  task automatic test_random_traffic(int count, int gap_pct, int stall);
    int         first;
    int         pick;
    logic [7:0] icw1;
    logic       paused;
    first        = cmds_sent;
    paused       = 1'b0;
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    while (cmds_sent < first + count) begin
      pick = $urandom_range(99);
      if (!paused && cmds_sent >= first + count / 2) begin
        paused = 1'b1;
        wait_for_drain();
      end
      if (pick < 33) begin
        pic_level(3'($urandom_range(7)), $urandom_range(9) < 7);
      end else if (pick < 53) begin
        pic_ack();
      end else if (pick < 66) begin
        pic_read(1'($urandom));
      end else if (pick < 70) begin
        pic_write(PORT_CTRL, {pic_pkg::OCW2_SPECIFIC_EOI, 2'b00, 3'($urandom_range(7))});
      end else if (pick < 74) begin
        pic_write(PORT_CTRL, {pic_pkg::OCW2_NONSPECIFIC_EOI, 2'b00, 3'($urandom_range(7))});
      end else if (pick < 77) begin
        pic_write(PORT_CTRL, {3'($urandom), 2'b00, 3'($urandom)});
      end else if (pick < 82) begin
        pic_write(PORT_CTRL, {3'($urandom), 2'b01, 3'($urandom)});
      end else if (pick < 90) begin
        pic_write(PORT_MASK, 8'($urandom));
      end else if (pick < 95) begin
        icw1 = 8'($urandom) | 8'h10;
        pic_write(PORT_CTRL, icw1);
        while (shadow_step != pic_pkg::STEP_DONE) begin
          pic_write(PORT_MASK, 8'($urandom));
        end
        pic_write(PORT_MASK, 8'($urandom));
      end else begin
        send_cmd(pic_pkg::cmd_t'($urandom_range(3)), 1'($urandom), 8'($urandom),
                 3'($urandom), 1'($urandom));
      end
    end
  endtask

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    m_axis_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  task automatic report_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
    end
  endtask

  // Every response transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    pic_pkg::pic_result_t want;
    pic_pkg::pic_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = pic_pkg::pic_result_t'(m_axis_tdata[20:0]);
      if (pending_responses.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual 0x%0h", $time,
                 m_axis_tdata);
      end else begin
        want = pending_responses.pop_front();
        report_field("read_data", int'(want.read_data), int'(got.read_data));
        report_field("ack_valid", int'(want.ack_valid), int'(got.ack_valid));
        report_field("ack_irq", int'(want.ack_irq), int'(got.ack_irq));
        report_field("int_pending", int'(want.int_pending), int'(got.int_pending));
        report_field("vector_base", int'(want.vector_base), int'(got.vector_base));
        report_field("zero fill", 0, int'(m_axis_tdata[23:21]));
      end
    end
  end

  // Counts cycles with no transaction on either side; a stuck handshake ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    shadow_irr      = 8'h00;
    shadow_isr      = 8'h00;
    shadow_imr      = pic_pkg::MASK_RESET;
    shadow_read_isr = 1'b0;
    shadow_step     = pic_pkg::STEP_IDLE;
    shadow_icw1     = 8'h00;
    shadow_vector   = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_power_on();
    test_init_short();
    test_ack_and_eoi();
    test_ocw_and_mask();

    // Flow-control phases: none, sender gaps, receiver stalls, then both.
    test_random_traffic(410, 0, 0);
    test_random_traffic(410, 63, 0);
    test_random_traffic(410, 0, 63);
    test_random_traffic(410, 26, 26);

    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_responses.size() != 0) begin
      errors++;
      $display("%0t: %0d responses never arrived", $time, pending_responses.size());
    end

    $display("Covered %0d commands in four flow-control phases with one forced drain each.",
             cmds_sent);
    $display("Lines granted: %0d, EOIs issued: %0d, ICW1 restarts: %0d, errors: %0d.",
             grants_seen, eois_seen, reinits_seen, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
